/* hw/rtl/salsa20_stream_cipher_macros.svh */
// Assertion macros used by the cipher top level
`ifndef SALSA20_STREAM_CIPHER_MACROS_SVH
`define SALSA20_STREAM_CIPHER_MACROS_SVH

// same-cycle implication, checked on clk, quiet during rst
`define SALSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, quiet during rst
`define SALSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/salsa20_pkg.sv */
// Types, constants and round functions of the Salsa20 cipher
package salsa20_pkg;

  typedef logic [31:0] word_t;
  typedef logic [63:0] dword_t;
  typedef logic [15:0][31:0] state_t;
  typedef logic [3:0] widx_t;

  localparam int unsigned ROUNDS = 20;
  localparam int unsigned RND_W = $clog2(ROUNDS);
  localparam int unsigned KS_WORDS = 8;
  localparam int unsigned POS_W = $clog2(KS_WORDS);
  localparam int unsigned ADDR_W = 6;

  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};
  localparam word_t TAU [4] = '{32'h61707865, 32'h3120646e, 32'h79622d36, 32'h6b206574};

  localparam widx_t COL_IDX [4][4] = '{'{4'd0, 4'd4, 4'd8, 4'd12},
                                       '{4'd5, 4'd9, 4'd13, 4'd1},
                                       '{4'd10, 4'd14, 4'd2, 4'd6},
                                       '{4'd15, 4'd3, 4'd7, 4'd11}};
  localparam widx_t ROW_IDX [4][4] = '{'{4'd0, 4'd1, 4'd2, 4'd3},
                                       '{4'd5, 4'd6, 4'd7, 4'd4},
                                       '{4'd10, 4'd11, 4'd8, 4'd9},
                                       '{4'd15, 4'd12, 4'd13, 4'd14}};

  typedef enum logic [2:0] {
    REG_KEY_A = 3'd0,
    REG_KEY_B = 3'd1,
    REG_KEY_C = 3'd2,
    REG_KEY_D = 3'd3,
    REG_MODE  = 3'd4,
    REG_NONCE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    dword_t key_a;
    dword_t key_b;
    dword_t key_c;
    dword_t key_d;
    logic   long_mode;
    dword_t nonce;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic init_state;
    logic do_round;
    logic row_round;
    logic feed;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic block_start;
    logic out_free;
  } status_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic qr_t quarter_round(input word_t a, input word_t b,
                                        input word_t c, input word_t d);
    qr_t r;
    word_t sum;
    sum = a + d;
    r.b = b ^ rotl(sum, 7);
    sum = r.b + a;
    r.c = c ^ rotl(sum, 9);
    sum = r.c + r.b;
    r.d = d ^ rotl(sum, 13);
    sum = r.d + r.c;
    r.a = a ^ rotl(sum, 18);
    return r;
  endfunction

endpackage

/* hw/rtl/salsa20_stream_cipher.sv */
// Salsa20/20 stream cipher top level with APB-style register port
// Results are registered. An item at block start first runs the 20 single-round passes
// of the round core and the feed-forward; every eighth item (and the first after a message
// end) starts a block. No new item is taken until the result is written (in_stall high).
// Reset (synchronous, rst high): counter, block position, sequencer, output valid
// and registers to defaults (long key mode on); keystream store is not cleared.
`include "salsa20_stream_cipher_macros.svh"

module salsa20_stream_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_in,
  input  logic [3:0]  byte_count,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] data_out,
  output logic [3:0]  byte_count_out,
  output logic        message_end_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [salsa20_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  salsa20_pkg::cfg_t    cfg;
  salsa20_pkg::cmd_t    cmd;
  salsa20_pkg::status_t status;
  salsa20_pkg::reg_idx_t reg_idx;
  logic cfg_write;
  logic cfg_hit;
  logic cfg_clear;
  logic [63:0] pad_bytes;

  assign pready    = 1'b1;
  assign reg_idx   = salsa20_pkg::reg_idx_t'(paddr[5:3]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_clear = cfg_write && cfg_hit;
  assign pad_bytes = data_out >> {byte_count_out, 3'b000};

  always_comb begin
    cfg_hit = 1'b1;
    prdata  = '0;
    unique case (reg_idx)
      salsa20_pkg::REG_KEY_A: prdata = cfg.key_a;
      salsa20_pkg::REG_KEY_B: prdata = cfg.key_b;
      salsa20_pkg::REG_KEY_C: prdata = cfg.key_c;
      salsa20_pkg::REG_KEY_D: prdata = cfg.key_d;
      salsa20_pkg::REG_MODE:  prdata = {63'd0, cfg.long_mode};
      salsa20_pkg::REG_NONCE: prdata = cfg.nonce;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_a     <= '0;
      cfg.key_b     <= '0;
      cfg.key_c     <= '0;
      cfg.key_d     <= '0;
      cfg.long_mode <= 1'b1;
      cfg.nonce     <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        salsa20_pkg::REG_KEY_A: cfg.key_a     <= pwdata;
        salsa20_pkg::REG_KEY_B: cfg.key_b     <= pwdata;
        salsa20_pkg::REG_KEY_C: cfg.key_c     <= pwdata;
        salsa20_pkg::REG_KEY_D: cfg.key_d     <= pwdata;
        salsa20_pkg::REG_MODE:  cfg.long_mode <= pwdata[0];
        salsa20_pkg::REG_NONCE: cfg.nonce     <= pwdata;
        default: ;
      endcase
    end
  end

  salsa20_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  salsa20_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg             (cfg),
    .cfg_clear       (cfg_clear),
    .data_in         (data_in),
    .byte_count      (byte_count),
    .message_end     (message_end),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .data_out        (data_out),
    .byte_count_out  (byte_count_out),
    .message_end_out (message_end_out)
  );

  `SALSA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")
  `SALSA_ASSERT_IMP(a_count_range, out_valid, byte_count_out <= 4'd8, "byte count above eight")
  `SALSA_ASSERT_IMP(a_pad_zero, out_valid && byte_count_out < 4'd8, pad_bytes == 64'd0, "pad not zero")
  `SALSA_ASSERT_IMP(a_block_gen_busy, cmd.do_round || cmd.feed, in_stall, "round while idle")

endmodule

/* hw/rtl/salsa20_ctrl.sv */
// Sequencer for item intake, block generation and result write
module salsa20_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  salsa20_pkg::status_t status,
  output salsa20_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_FEED,
    S_XOR
  } state_t;

  state_t state;
  logic [salsa20_pkg::RND_W-1:0] rnd_cnt;
  logic last_round;

  assign last_round = (rnd_cnt == salsa20_pkg::RND_W'(salsa20_pkg::ROUNDS - 1));
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load_item  = in_valid;
        cmd.init_state = in_valid && status.block_start;
      end
      S_ROUND: begin
        cmd.do_round  = 1'b1;
        cmd.row_round = rnd_cnt[0];
      end
      S_FEED: begin
        cmd.feed = 1'b1;
      end
      S_XOR: begin
        cmd.write_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rnd_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          rnd_cnt <= '0;
          if (in_valid) begin
            state <= status.block_start ? S_ROUND : S_XOR;
          end
        end
        S_ROUND: begin
          rnd_cnt <= rnd_cnt + 1'b1;
          if (last_round) begin
            state <= S_FEED;
          end
        end
        S_FEED: begin
          state <= S_XOR;
        end
        S_XOR: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/salsa20_dp.sv */
// Datapath: round core, keystream store, block counter and output register
module salsa20_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  salsa20_pkg::cmd_t    cmd,
  output salsa20_pkg::status_t status,
  input  salsa20_pkg::cfg_t    cfg,
  input  logic                 cfg_clear,
  input  logic [63:0]          data_in,
  input  logic [3:0]           byte_count,
  input  logic                 message_end,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [63:0]          data_out,
  output logic [3:0]           byte_count_out,
  output logic                 message_end_out
);

  salsa20_pkg::word_t  cw [4];
  salsa20_pkg::dword_t hi0;
  salsa20_pkg::dword_t hi1;
  salsa20_pkg::state_t init_s;
  salsa20_pkg::state_t st;
  salsa20_pkg::state_t col_s;
  salsa20_pkg::state_t row_s;
  salsa20_pkg::qr_t    qc;
  salsa20_pkg::qr_t    qr;
  salsa20_pkg::dword_t ks [salsa20_pkg::KS_WORDS];
  salsa20_pkg::dword_t counter;
  logic [salsa20_pkg::POS_W-1:0] pos;
  logic [63:0] data_q;
  logic [3:0]  count_q;
  logic        end_q;
  logic [63:0] mask;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cw[i] = cfg.long_mode ? salsa20_pkg::SIGMA[i] : salsa20_pkg::TAU[i];
    end
  end

  assign hi0 = cfg.long_mode ? cfg.key_c : cfg.key_a;
  assign hi1 = cfg.long_mode ? cfg.key_d : cfg.key_b;

  always_comb begin
    init_s[0]  = cw[0];
    init_s[1]  = cfg.key_a[31:0];
    init_s[2]  = cfg.key_a[63:32];
    init_s[3]  = cfg.key_b[31:0];
    init_s[4]  = cfg.key_b[63:32];
    init_s[5]  = cw[1];
    init_s[6]  = cfg.nonce[31:0];
    init_s[7]  = cfg.nonce[63:32];
    init_s[8]  = counter[31:0];
    init_s[9]  = counter[63:32];
    init_s[10] = cw[2];
    init_s[11] = hi0[31:0];
    init_s[12] = hi0[63:32];
    init_s[13] = hi1[31:0];
    init_s[14] = hi1[63:32];
    init_s[15] = cw[3];
  end

  always_comb begin
    col_s = st;
    row_s = st;
    qc = '0;
    qr = '0;
    for (int q = 0; q < 4; q++) begin
      qc = salsa20_pkg::quarter_round(st[salsa20_pkg::COL_IDX[q][0]],
                                      st[salsa20_pkg::COL_IDX[q][1]],
                                      st[salsa20_pkg::COL_IDX[q][2]],
                                      st[salsa20_pkg::COL_IDX[q][3]]);
      col_s[salsa20_pkg::COL_IDX[q][0]] = qc.a;
      col_s[salsa20_pkg::COL_IDX[q][1]] = qc.b;
      col_s[salsa20_pkg::COL_IDX[q][2]] = qc.c;
      col_s[salsa20_pkg::COL_IDX[q][3]] = qc.d;
      qr = salsa20_pkg::quarter_round(st[salsa20_pkg::ROW_IDX[q][0]],
                                      st[salsa20_pkg::ROW_IDX[q][1]],
                                      st[salsa20_pkg::ROW_IDX[q][2]],
                                      st[salsa20_pkg::ROW_IDX[q][3]]);
      row_s[salsa20_pkg::ROW_IDX[q][0]] = qr.a;
      row_s[salsa20_pkg::ROW_IDX[q][1]] = qr.b;
      row_s[salsa20_pkg::ROW_IDX[q][2]] = qr.c;
      row_s[salsa20_pkg::ROW_IDX[q][3]] = qr.d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_state) begin
      st <= init_s;
    end else if (cmd.do_round) begin
      st <= cmd.row_round ? row_s : col_s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed) begin
      for (int i = 0; i < int'(salsa20_pkg::KS_WORDS); i++) begin
        ks[i] <= {salsa20_pkg::word_t'(st[2*i+1] + init_s[2*i+1]),
                  salsa20_pkg::word_t'(st[2*i] + init_s[2*i])};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      counter <= '0;
    end else if (cmd.feed) begin
      counter <= counter + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      data_q  <= data_in;
      count_q <= byte_count[3] ? 4'd8 : byte_count;
      end_q   <= message_end;
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = (4'(b) < count_q) ? 8'hFF : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
      pos       <= end_q ? '0 : pos + 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      data_out        <= (data_q ^ ks[pos]) & mask;
      byte_count_out  <= count_q;
      message_end_out <= end_q;
    end
  end

  assign status.block_start = (pos == '0);
  assign status.out_free    = !out_valid || !out_stall;

endmodule

/* test/salsa20_stream_cipher_tb.sv */
// Self-checking testbench for the Salsa20/20 stream cipher
module salsa20_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int UNMAPPED_REG = 7;
  localparam int PHASES = 12;
  localparam int WORDS_PER_PHASE = 140;
  localparam logic [31:0] EXPAND_32 [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32,
                                            32'h6b206574};
  localparam logic [31:0] EXPAND_16 [4] = '{32'h61707865, 32'h3120646e, 32'h79622d36,
                                            32'h6b206574};

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } cipher_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] data_in;
  logic [3:0]  byte_count;
  logic        message_end;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] data_out;
  logic [3:0]  byte_count_out;
  logic        message_end_out;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [salsa20_pkg::ADDR_W-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  salsa20_pkg::cfg_t cfg_copy;
  logic [63:0] block_ctr;
  logic [63:0] ks_word [8];
  logic [2:0]  ks_pos;
  logic [31:0] mix_state [16];

  cipher_word_t expected_words [$];
  int unsigned  cycles;
  int           errors;
  int           tx_gap_pct;
  int           rx_stall_pct;
  int           hold_request;

  salsa20_stream_cipher i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_in        (data_in),
    .byte_count     (byte_count),
    .message_end    (message_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_out       (data_out),
    .byte_count_out (byte_count_out),
    .message_end_out(message_end_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void quarter_mix(input int a, input int b, input int c, input int d);
    mix_state[b] = mix_state[b] ^ rotl32(mix_state[a] + mix_state[d], 7);
    mix_state[c] = mix_state[c] ^ rotl32(mix_state[b] + mix_state[a], 9);
    mix_state[d] = mix_state[d] ^ rotl32(mix_state[c] + mix_state[b], 13);
    mix_state[a] = mix_state[a] ^ rotl32(mix_state[d] + mix_state[c], 18);
  endfunction

  function automatic void refill_keystream();
    logic [31:0] init [16];
    logic [31:0] cw [4];
    logic [63:0] hi0;
    logic [63:0] hi1;
    for (int i = 0; i < 4; i++) begin
      cw[i] = cfg_copy.long_mode ? EXPAND_32[i] : EXPAND_16[i];
    end
    hi0 = cfg_copy.long_mode ? cfg_copy.key_c : cfg_copy.key_a;
    hi1 = cfg_copy.long_mode ? cfg_copy.key_d : cfg_copy.key_b;
    init[0]  = cw[0];
    init[1]  = cfg_copy.key_a[31:0];
    init[2]  = cfg_copy.key_a[63:32];
    init[3]  = cfg_copy.key_b[31:0];
    init[4]  = cfg_copy.key_b[63:32];
    init[5]  = cw[1];
    init[6]  = cfg_copy.nonce[31:0];
    init[7]  = cfg_copy.nonce[63:32];
    init[8]  = block_ctr[31:0];
    init[9]  = block_ctr[63:32];
    init[10] = cw[2];
    init[11] = hi0[31:0];
    init[12] = hi0[63:32];
    init[13] = hi1[31:0];
    init[14] = hi1[63:32];
    init[15] = cw[3];
    mix_state = init;
    for (int r = 0; r < 10; r++) begin
      quarter_mix(0, 4, 8, 12);
      quarter_mix(5, 9, 13, 1);
      quarter_mix(10, 14, 2, 6);
      quarter_mix(15, 3, 7, 11);
      quarter_mix(0, 1, 2, 3);
      quarter_mix(5, 6, 7, 4);
      quarter_mix(10, 11, 8, 9);
      quarter_mix(15, 12, 13, 14);
    end
    for (int i = 0; i < 8; i++) begin
      ks_word[i] = {mix_state[2*i+1] + init[2*i+1], mix_state[2*i] + init[2*i]};
    end
    block_ctr = block_ctr + 64'd1;
  endfunction

  function automatic cipher_word_t cipher_word(input logic [63:0] data, input logic [3:0] cnt,
                                               input logic last);
    cipher_word_t w;
    logic [3:0]   n;
    logic [63:0]  mask;
    n = (cnt > 4'd8) ? 4'd8 : cnt;
    mask = (n == 4'd8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
    if (ks_pos == 3'd0) refill_keystream();
    w.data = (data ^ ks_word[ks_pos]) & mask;
    w.count = n;
    w.last = last;
    ks_pos = last ? 3'd0 : ks_pos + 3'd1;
    return w;
  endfunction

  function automatic void cfg_update(input int idx, input logic [63:0] v);
    case (idx)
      salsa20_pkg::REG_KEY_A: cfg_copy.key_a = v;
      salsa20_pkg::REG_KEY_B: cfg_copy.key_b = v;
      salsa20_pkg::REG_KEY_C: cfg_copy.key_c = v;
      salsa20_pkg::REG_KEY_D: cfg_copy.key_d = v;
      salsa20_pkg::REG_MODE:  cfg_copy.long_mode = v[0];
      salsa20_pkg::REG_NONCE: cfg_copy.nonce = v;
      default:   return;
    endcase
    block_ctr = 64'd0;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(2))
      0: return 64'd0;
      1: return {64{1'b1}};
      default: return rand64();
    endcase
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    cipher_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        flag_error($sformatf("unexpected word: data %h count %0d end %0b",
                             data_out, byte_count_out, message_end_out));
      end else begin
        want = expected_words.pop_front();
        if (data_out !== want.data || byte_count_out !== want.count ||
            message_end_out !== want.last) begin
          flag_error($sformatf("mismatch: exp data %h count %0d end %0b, got %h %0d %0b",
                               want.data, want.count, want.last,
                               data_out, byte_count_out, message_end_out));
        end
      end
    end
  end

  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct) begin
        out_stall <= 1'b1;
        stall_left = pick_gap() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [63:0] data, input logic [3:0] cnt, input logic last);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    data_in <= data;
    byte_count <= cnt;
    message_end <= last;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(cipher_word(data, cnt, last));
    if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
      gap = pick_gap();
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_message(input int len, input bit noisy, input bit open_end);
    logic [3:0] cnt;
    logic       last;
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1) && !open_end;
      cnt = last ? 4'($urandom_range(8, 1)) : 4'd8;
      if (noisy && $urandom_range(99) < 10) cnt = 4'($urandom_range(15, 0));
      send_word(rand64(), cnt, last);
    end
  endtask

  task automatic apb_write(input int idx, input logic [63:0] v);
    logic [salsa20_pkg::ADDR_W-1:0] addr;
    addr = salsa20_pkg::ADDR_W'(idx * 8);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_update(idx, v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_default_key();
    tx_gap_pct = 30;
    rx_stall_pct = 30;
    send_word({64{1'b1}}, 4'd8, 1'b0);
    send_word(64'd0, 4'd8, 1'b0);
    send_word(rand64(), 4'd15, 1'b0);
    send_word(rand64(), 4'd9, 1'b0);
    send_word(rand64(), 4'd0, 1'b0);
    send_word(rand64(), 4'd1, 1'b0);
    send_word({64{1'b1}}, 4'd7, 1'b1);
    for (int i = 0; i < 8; i++) send_word(rand64(), 4'd8, 1'b0);
    send_word(rand64(), 4'd4, 1'b1);
    wait_idle();
  endtask

  task automatic test_config_midblock();
    for (int i = 0; i < 3; i++) send_word(rand64(), 4'd8, 1'b0);
    wait_idle();
    apb_write(UNMAPPED_REG, {64{1'b1}});
    apb_write(salsa20_pkg::REG_KEY_A, rand64());
    for (int i = 0; i < 5; i++) send_word(rand64(), 4'd8, 1'b0);
    send_word(rand64(), 4'd2, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    @(posedge clk);
    hold_request = 300;
    send_message(40, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int sent;
    int len;
    int pct_pick [3];
    pct_pick = '{0, 20, 50};
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        for (int r = salsa20_pkg::REG_KEY_A; r <= salsa20_pkg::REG_KEY_D; r++) begin
          apb_write(r, 64'd0);
        end
        apb_write(salsa20_pkg::REG_MODE, 64'd0);
        apb_write(salsa20_pkg::REG_NONCE, 64'd0);
      end else if (p == 1) begin
        for (int r = salsa20_pkg::REG_KEY_A; r <= salsa20_pkg::REG_KEY_D; r++) begin
          apb_write(r, {64{1'b1}});
        end
        apb_write(salsa20_pkg::REG_MODE, {64{1'b1}});
        apb_write(salsa20_pkg::REG_NONCE, {64{1'b1}});
      end else begin
        for (int r = salsa20_pkg::REG_KEY_A; r <= salsa20_pkg::REG_KEY_D; r++) begin
          if ($urandom_range(1)) apb_write(r, pick_value());
        end
        if ($urandom_range(1)) apb_write(salsa20_pkg::REG_MODE, rand64());
        if ($urandom_range(1)) apb_write(salsa20_pkg::REG_NONCE, pick_value());
        if ($urandom_range(3) == 0) apb_write(UNMAPPED_REG, rand64());
      end
      tx_gap_pct = pct_pick[$urandom_range(2)];
      rx_stall_pct = pct_pick[$urandom_range(2)];
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(20, 1);
        send_message(len, $urandom_range(4) == 0, 1'b0);
        sent += len;
      end
      if ($urandom_range(1)) send_message($urandom_range(5, 1), 1'b0, 1'b1);
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_in = '0;
    byte_count = '0;
    message_end = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    errors = 0;
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    hold_request = 0;
    cfg_copy = '0;
    cfg_copy.long_mode = 1'b1;
    block_ctr = '0;
    ks_pos = '0;
    for (int i = 0; i < 8; i++) ks_word[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_key();
    test_config_midblock();
    test_backpressure();
    test_random_traffic();

    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/salsa20_pkg.sv
hw/rtl/salsa20_ctrl.sv
hw/rtl/salsa20_dp.sv
hw/rtl/salsa20_stream_cipher.sv
test/salsa20_stream_cipher_tb.sv
